### hw/rtl/chm_pkg.sv
// ----------------------------------------------------------------------------
// chm_pkg: shared types and constants for the chained hash map engine
// Table sizes, command, status and register codes, datapath command and
// status structs.
// ----------------------------------------------------------------------------
package chm_pkg;

  localparam int BUCKETS = 256;
  localparam int NODES   = 1024;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_LOOKUP = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EXISTS    = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  localparam logic [3:0] ADDR_LIMIT = 4'd0;
  localparam logic [3:0] ADDR_SEED  = 4'd8;

  typedef struct packed {
    logic clear_step;  // write one clear entry (bucket head, node link)
    logic load;        // capture input item, start hash
    logic hash_step;   // advance hash pipeline
    logic rd_head;     // read bucket head of key
    logic take_head;   // current node <- head data
    logic rd_node;     // read key/link of current node
    logic advance;     // prev <- cur, cur <- link
    logic do_insert;   // write new node, link it in at bucket head
    logic rd_free;     // read link of free head
    logic take_free;   // free_head <- read link
    logic do_remove;   // unlink found node
    logic do_remove2;  // push onto free list
    logic rd_value;    // read value of current node
    logic set_result;  // latch result fields
    logic push_out;    // move result into output register
    logic [1:0] status;
    logic use_value;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic cur_nil;
    logic key_match;
    logic free_nil;
    logic limit_hit;
  } dp_stat_t;

endpackage

### hw/rtl/chm_datapath.sv
// ----------------------------------------------------------------------------
// chm_datapath: memories, hash, chain walk registers and counters
// Bucket heads and node links are cleared by a sweep after reset.
// ----------------------------------------------------------------------------
module chm_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  chm_pkg::dp_cmd_t   cmd,
  output chm_pkg::dp_stat_t  stat,
  input  logic [1:0]         in_cmd,
  input  logic [63:0]        in_key,
  input  logic [63:0]        in_value,
  input  logic [10:0]        entry_limit,
  input  logic [63:0]        mix_seed,
  output logic [1:0]         op_cmd,
  output logic [1:0]         res_status,
  output logic [63:0]        res_value,
  output logic [10:0]        res_count
);
  localparam int BUCKETS = chm_pkg::BUCKETS;
  localparam int NODES   = chm_pkg::NODES;
  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int LW = $clog2(NODES + 1);
  localparam int NW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int CW = (NODES > BUCKETS) ? LW : ((BUCKETS > 1) ? $clog2(BUCKETS + 1) : 1);
  localparam logic [LW-1:0] NIL = LW'(NODES);

  logic [LW-1:0] head_mem [BUCKETS];
  logic [LW-1:0] link_mem [NODES];
  logic [63:0]   key_mem  [NODES];
  logic [63:0]   val_mem  [NODES];

  logic [CW-1:0] clr_r;
  logic [63:0] key_r, val_r, h_r;
  logic [1:0] cmd_r;
  logic [2:0] hph_r;
  logic [BW-1:0] bkt_r;
  logic [LW-1:0] cur_r, prev_r, free_r, head_q, link_q, fl_q;
  logic [63:0] nkey_q, nval_q;
  logic [10:0] cnt_r;
  logic [1:0] st_r;
  logic [63:0] rv_r;
  logic [1:0] ost_r;
  logic [63:0] orv_r;
  logic [10:0] ocnt_r;
  logic [63:0] hx;

  // xor-shift mix, one step per cycle
  always_comb begin
    hx = h_r;
    case (hph_r)
      3'd0: hx = h_r ^ (h_r >> 30);
      3'd1: hx = h_r ^ (h_r << 21);
      3'd2: hx = h_r ^ (h_r >> 27);
      3'd3: hx = h_r ^ (h_r << 11);
      3'd4: hx = h_r ^ (h_r >> 31);
      default: hx = h_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r  <= '0;
      free_r <= '0;
      cnt_r  <= '0;
      hph_r  <= '0;
      ost_r  <= '0;
      orv_r  <= '0;
      ocnt_r <= '0;
    end else begin
      if (cmd.clear_step) begin
        if (clr_r < CW'(BUCKETS)) head_mem[clr_r[BW-1:0]] <= NIL;
        if (clr_r < CW'(NODES)) link_mem[clr_r[NW-1:0]] <= LW'(clr_r) + LW'(1);
        clr_r <= clr_r + CW'(1);
      end
      if (cmd.load) begin
        key_r <= in_key;
        val_r <= in_value;
        cmd_r <= in_cmd;
        h_r   <= in_key ^ mix_seed;
        hph_r <= '0;
      end
      if (cmd.hash_step) begin
        h_r   <= hx;
        hph_r <= hph_r + 3'd1;
        bkt_r <= hx[BW-1:0];
      end
      if (cmd.rd_head) head_q <= head_mem[bkt_r];
      if (cmd.take_head) begin
        cur_r  <= head_q;
        prev_r <= NIL;
      end
      if (cmd.rd_node) begin
        nkey_q <= key_mem[cur_r[NW-1:0]];
        link_q <= link_mem[cur_r[NW-1:0]];
      end
      if (cmd.advance) begin
        prev_r <= cur_r;
        cur_r  <= link_q;
      end
      if (cmd.rd_free) fl_q <= link_mem[free_r[NW-1:0]];
      if (cmd.take_free) free_r <= fl_q;
      if (cmd.do_insert) begin
        key_mem[free_r[NW-1:0]]  <= key_r;
        val_mem[free_r[NW-1:0]]  <= val_r;
        link_mem[free_r[NW-1:0]] <= head_q;
        head_mem[bkt_r] <= free_r;
        cnt_r <= cnt_r + 11'd1;
      end
      if (cmd.do_remove) begin
        if (prev_r != NIL) link_mem[prev_r[NW-1:0]] <= link_q;
        else head_mem[bkt_r] <= link_q;
        if (cnt_r != 11'd0) cnt_r <= cnt_r - 11'd1;
      end
      if (cmd.do_remove2) begin
        link_mem[cur_r[NW-1:0]] <= free_r;
        free_r <= cur_r;
      end
      if (cmd.rd_value) nval_q <= val_mem[cur_r[NW-1:0]];
      if (cmd.set_result) begin
        st_r <= cmd.status;
        rv_r <= cmd.use_value ? nval_q : 64'd0;
      end
      if (cmd.push_out) begin
        ost_r  <= st_r;
        orv_r  <= rv_r;
        ocnt_r <= cnt_r;
      end
    end
  end

  assign stat.clear_done = (clr_r >= CW'(NODES)) && (clr_r >= CW'(BUCKETS));
  assign stat.cur_nil    = (cur_r >= NIL);
  assign stat.key_match  = (nkey_q == key_r);
  assign stat.free_nil   = (free_r >= NIL);
  assign stat.limit_hit  = ({1'b0, cnt_r} + 12'd1) > {1'b0, entry_limit};

  assign op_cmd     = cmd_r;
  assign res_status = ost_r;
  assign res_value  = orv_r;
  assign res_count  = ocnt_r;
endmodule

### hw/rtl/chm_ctrl.sv
// ----------------------------------------------------------------------------
// chm_ctrl: operation sequencer
// Clears the tables, hashes the key, walks the chain and commits updates.
// ----------------------------------------------------------------------------
module chm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  logic              out_fire,
  input  logic [1:0]        op_cmd,
  input  chm_pkg::dp_stat_t stat,
  output chm_pkg::dp_cmd_t  cmd,
  output logic              idle,
  output logic              res_valid
);
  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HASH, S_HEAD, S_TAKE, S_RDN, S_CMP,
    S_INS, S_FREE, S_REM, S_REM2, S_VAL, S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic valid_r, valid_nxt;
  logic [2:0] hcnt_r, hcnt_nxt;

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    valid_nxt = valid_r && !out_fire;
    hcnt_nxt = hcnt_r;
    case (state_r)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_fire) begin
          cmd.load = 1'b1;
          hcnt_nxt = '0;
          state_nxt = S_HASH;
        end
      end
      S_HASH: begin
        cmd.hash_step = 1'b1;
        hcnt_nxt = hcnt_r + 3'd1;
        if (hcnt_r == 3'd4) state_nxt = S_HEAD;
      end
      S_HEAD: begin
        cmd.rd_head = 1'b1;
        cmd.rd_free = 1'b1;
        state_nxt = S_TAKE;
      end
      S_TAKE: begin
        cmd.take_head = 1'b1;
        if (op_cmd inside {chm_pkg::CMD_INSERT, chm_pkg::CMD_LOOKUP,
                           chm_pkg::CMD_REMOVE}) begin
          state_nxt = S_RDN;
        end else begin
          cmd.set_result = 1'b1;
          cmd.status = chm_pkg::ST_NOT_FOUND;
          state_nxt = S_DONE;
        end
      end
      S_RDN: begin
        cmd.rd_node = 1'b1;
        state_nxt = S_CMP;
        if (stat.cur_nil) begin
          cmd.rd_node = 1'b0;
          if (op_cmd == chm_pkg::CMD_INSERT) begin
            if (stat.limit_hit || stat.free_nil) begin
              cmd.set_result = 1'b1;
              cmd.status = chm_pkg::ST_FULL;
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_INS;
            end
          end else begin
            cmd.set_result = 1'b1;
            cmd.status = chm_pkg::ST_NOT_FOUND;
            state_nxt = S_DONE;
          end
        end
      end
      S_CMP: begin
        if (stat.key_match) begin
          case (op_cmd)
            chm_pkg::CMD_INSERT: begin
              cmd.set_result = 1'b1;
              cmd.status = chm_pkg::ST_EXISTS;
              state_nxt = S_DONE;
            end
            chm_pkg::CMD_LOOKUP: begin
              cmd.rd_value = 1'b1;
              state_nxt = S_VAL;
            end
            default: state_nxt = S_REM;
          endcase
        end else begin
          cmd.advance = 1'b1;
          state_nxt = S_RDN;
        end
      end
      S_INS: begin
        cmd.do_insert = 1'b1;
        cmd.take_free = 1'b1;
        cmd.set_result = 1'b1;
        cmd.status = chm_pkg::ST_OK;
        state_nxt = S_DONE;
      end
      S_REM: begin
        cmd.do_remove = 1'b1;
        state_nxt = S_REM2;
      end
      S_REM2: begin
        cmd.do_remove2 = 1'b1;
        cmd.set_result = 1'b1;
        cmd.status = chm_pkg::ST_OK;
        state_nxt = S_DONE;
      end
      S_VAL: begin
        cmd.set_result = 1'b1;
        cmd.status = chm_pkg::ST_OK;
        cmd.use_value = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!valid_r || out_fire) begin
          cmd.push_out = 1'b1;
          valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      valid_r <= 1'b0;
      hcnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      hcnt_r  <= hcnt_nxt;
    end
  end

  assign idle = (state_r == S_IDLE);
  assign res_valid = valid_r;
endmodule

### hw/rtl/chained_hash_map_engine.sv
// ----------------------------------------------------------------------------
// chained_hash_map_engine: key/value map on a separate-chaining hash table
// The time from accept to result depends on the outcome (miss, full, insert,
// duplicate, lookup hit, remove) and grows with each node walked past.
// One operation at a time; the next transaction can enter in the cycle the
// result appears, and may enter while that result waits in the output register.
// Reset: synchronous; a sweep over the tables then builds the free list, no accepts.
// ----------------------------------------------------------------------------
module chained_hash_map_engine (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [135:0] in_tdata,   // cmd[1:0], key[65:2], value[129:66], zero
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [79:0]  out_tdata,  // status[1:0], read_value[65:2], live_count[76:66]
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [3:0]   cfg_paddr,
  input  logic [63:0]  cfg_pwdata,
  output logic [63:0]  cfg_prdata,
  output logic         cfg_pready
);
  logic [10:0] limit_r;
  logic [63:0] seed_r;
  chm_pkg::dp_cmd_t  dcmd;
  chm_pkg::dp_stat_t dstat;
  logic idle, res_valid, in_fire, out_fire;
  logic [1:0] op_cmd, res_status;
  logic [63:0] res_value;
  logic [10:0] res_count;

  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= 11'd768;
      seed_r  <= 64'd0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (cfg_paddr)
        chm_pkg::ADDR_LIMIT: limit_r <= cfg_pwdata[10:0];
        chm_pkg::ADDR_SEED:  seed_r  <= cfg_pwdata;
        default: ;
      endcase
    end
  end
  always_comb begin
    case (cfg_paddr)
      chm_pkg::ADDR_LIMIT: cfg_prdata = {53'd0, limit_r};
      chm_pkg::ADDR_SEED:  cfg_prdata = seed_r;
      default:             cfg_prdata = 64'd0;
    endcase
  end

  assign in_tready  = idle;
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = res_valid;
  assign out_fire   = out_tvalid && out_tready;
  assign out_tdata  = {3'd0, res_count, res_value, res_status};

  chm_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_fire(out_fire),
    .op_cmd(op_cmd), .stat(dstat), .cmd(dcmd), .idle(idle), .res_valid(res_valid)
  );

  chm_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(dcmd), .stat(dstat),
    .in_cmd(in_tdata[1:0]), .in_key(in_tdata[65:2]), .in_value(in_tdata[129:66]),
    .entry_limit(limit_r), .mix_seed(seed_r), .op_cmd(op_cmd),
    .res_status(res_status), .res_value(res_value), .res_count(res_count)
  );

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid) else $error("result dropped");
  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res_status != chm_pkg::ST_OK |-> res_value == 64'd0)
    else $error("value on failed op");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    res_count <= 11'(chm_pkg::NODES)) else $error("count exceeds pool");
`endif
endmodule
